// File: rtl/peer_slot_table_idle_evict_assert.svh
// Assertion macros shared by the peer slot table RTL.
`ifndef PEER_SLOT_TABLE_IDLE_EVICT_ASSERT_SVH
`define PEER_SLOT_TABLE_IDLE_EVICT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PSTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psti_pkg.sv
// Package with types and constants of the peer slot table.
package psti_pkg;

  // Default number of slots, slot zero included.
  localparam int unsigned SlotsDef = 15;

  // Idle timeout after reset: ten minutes in milliseconds.
  localparam logic [31:0] IdleTimeoutRst = 32'(10 * 60 * 1000);

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_MATCHED    = 3'd0,
    STAT_NEW        = 3'd1,
    STAT_REPLACED   = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_UNASSIGNED = 3'd4,
    STAT_OUT_OK     = 3'd5
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_OUT,
    S_MATCH,
    S_EVICT
  } state_e;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last;
  } entry_t;

endpackage

// File: rtl/peer_slot_table_idle_evict.sv
// Peer slot table: maps remote endpoints to relay slots with idle eviction.
//
// Usage: an item is accepted when start_i is high and busy_o is low. func_i
// selects an inbound lookup (endpoint in peer_ip_i and peer_port_i) or an
// outbound access to slot slot_sel_i; now_ms_i is the current time. Each item
// gives one result, shown on slot_out_o, status_o, out_ip_o and out_port_o for
// exactly one cycle while done_o is high; the receiver cannot stall it.
// The idle timeout is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while idle, as the block itself does not enforce this.
// Timing: the slot memory has one read port and one write port and is read one
// entry per cycle. An inbound item scans from slot one to the first empty or
// matching slot, else makes the idle scan, which ends in an idle slot or a full
// table. busy_o is already low in the cycle that shows the result, so the next
// item may be accepted then.
// Reset: the slot store reads as all empty at once through one valid flag per
// slot, and the idle timeout returns to ten minutes; no clearing pass is needed.
`include "peer_slot_table_idle_evict_assert.svh"

module peer_slot_table_idle_evict #(
  parameter int unsigned SLOTS = psti_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [31:0] peer_ip_i,
  input  logic [15:0] peer_port_i,
  input  logic [3:0]  slot_sel_i,
  input  logic [31:0] now_ms_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [3:0]  slot_out_o,
  output logic [2:0]  status_o,
  output logic [31:0] out_ip_o,
  output logic [15:0] out_port_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [IdxW-1:0] FirstIdx = IdxW'(1);

  psti_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic [31:0]      timeout_q;
  logic [31:0]      ip_q, now_q;
  logic [15:0]      port_q;

  // Slot memory and its valid flags.
  psti_pkg::entry_t mem_q [SLOTS];
  psti_pkg::entry_t rdata_q, rd_ent, wr_data;
  logic [SLOTS-1:0] valid_q;
  logic             rvalid_q;
  logic [IdxW-1:0]  rd_addr, wr_addr;
  logic             wr_en;

  // Result registers.
  logic             done_q, res_load;
  logic [3:0]       slot_q, res_slot;
  psti_pkg::status_e status_q, res_status;
  logic [31:0]      oip_q, res_ip;
  logic [15:0]      oport_q, res_port;

  logic accept;
  logic sel_bad;
  logic hit_empty, hit_match, hit_idle;

  assign accept  = start_i && (state_q == psti_pkg::S_IDLE);
  assign sel_bad = (slot_sel_i == 4'd0) || (32'(slot_sel_i) >= SLOTS);

  // An entry never written since reset reads as empty with time zero.
  assign rd_ent    = rvalid_q ? rdata_q : '0;
  assign hit_empty = (rd_ent.port == 16'd0);
  assign hit_match = (rd_ent.ip == ip_q) && (rd_ent.port == port_q);
  assign hit_idle  = ((now_q - rd_ent.last) >= timeout_q);

  // Memory access: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Valid flags and read-side flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr];
    end
  end

  // Control state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= psti_pkg::S_IDLE;
      cur_q     <= '0;
      timeout_q <= psti_pkg::IdleTimeoutRst;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      done_q  <= res_load;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Transaction fields held for the scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ip_q   <= peer_ip_i;
      port_q <= peer_port_i;
      now_q  <= now_ms_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      slot_q   <= res_slot;
      status_q <= res_status;
      oip_q    <= res_ip;
      oport_q  <= res_port;
    end
  end

  // Sequencer: next state, memory accesses and result selection.
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    rd_addr    = cur_q + FirstIdx;
    wr_en      = 1'b0;
    wr_addr    = cur_q;
    wr_data    = '{ip: ip_q, port: port_q, last: now_q};
    res_load   = 1'b0;
    res_slot   = 4'(cur_q);
    res_status = psti_pkg::STAT_FULL;
    res_ip     = '0;
    res_port   = '0;
    case (state_q)
      psti_pkg::S_IDLE: begin
        if (start_i) begin
          if (func_i) begin
            if (sel_bad) begin
              res_load   = 1'b1;
              res_slot   = slot_sel_i;
              res_status = psti_pkg::STAT_UNASSIGNED;
            end else begin
              rd_addr = IdxW'(slot_sel_i);
              cur_d   = IdxW'(slot_sel_i);
              state_d = psti_pkg::S_OUT;
            end
          end else begin
            rd_addr = FirstIdx;
            cur_d   = FirstIdx;
            state_d = psti_pkg::S_MATCH;
          end
        end
      end
      psti_pkg::S_OUT: begin
        res_load = 1'b1;
        state_d  = psti_pkg::S_IDLE;
        if (hit_empty) begin
          res_status = psti_pkg::STAT_UNASSIGNED;
        end else begin
          wr_en      = 1'b1;
          wr_data    = '{ip: rd_ent.ip, port: rd_ent.port, last: now_q};
          res_status = psti_pkg::STAT_OUT_OK;
          res_ip     = rd_ent.ip;
          res_port   = rd_ent.port;
        end
      end
      psti_pkg::S_MATCH: begin
        if (hit_empty || hit_match) begin
          wr_en      = 1'b1;
          res_load   = 1'b1;
          res_status = hit_empty ? psti_pkg::STAT_NEW : psti_pkg::STAT_MATCHED;
          state_d    = psti_pkg::S_IDLE;
        end else if (cur_q == LastIdx) begin
          // No empty or matching slot: restart at slot one for the idle scan.
          rd_addr = FirstIdx;
          cur_d   = FirstIdx;
          state_d = psti_pkg::S_EVICT;
        end else begin
          cur_d = cur_q + FirstIdx;
        end
      end
      psti_pkg::S_EVICT: begin
        if (hit_idle) begin
          wr_en      = 1'b1;
          res_load   = 1'b1;
          res_status = psti_pkg::STAT_REPLACED;
          state_d    = psti_pkg::S_IDLE;
        end else if (cur_q == LastIdx) begin
          res_load   = 1'b1;
          res_slot   = 4'(SLOTS);
          res_status = psti_pkg::STAT_FULL;
          state_d    = psti_pkg::S_IDLE;
        end else begin
          cur_d = cur_q + FirstIdx;
        end
      end
      default: begin
        state_d = psti_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o     = (state_q != psti_pkg::S_IDLE);
  assign done_o     = done_q;
  assign slot_out_o = slot_q;
  assign status_o   = status_q;
  assign out_ip_o   = oip_q;
  assign out_port_o = oport_q;

  // A full table always reports the slot count as its slot number.
  `PSTI_ASSERT_NOW(a_full_slot, clk_i, rst_ni, done_o && (status_o == psti_pkg::STAT_FULL), slot_out_o == 4'(SLOTS), "full result with wrong slot number")
  // Only a successful outbound access returns an endpoint.
  `PSTI_ASSERT_NOW(a_no_endpoint, clk_i, rst_ni, done_o && (status_o != psti_pkg::STAT_OUT_OK), (out_ip_o == 32'd0) && (out_port_o == 16'd0), "endpoint on a result that carries none")
  // Back-to-back results need a transaction accepted in the result cycle.
  `PSTI_ASSERT_NEXT(a_one_result, clk_i, rst_ni, done_o, !done_o || $past(start_i && !busy_o), "result without an accepted transaction")

endmodule

// File: bench/peer_slot_table_idle_evict_tb.sv
// Self-checking testbench for the peer slot table with idle eviction.
module peer_slot_table_idle_evict_tb;

  localparam int unsigned SLOTS = psti_pkg::SlotsDef;
  localparam int unsigned POOL_SIZE = 20;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 10;
  localparam logic FUNC_IN = 1'b0;
  localparam logic FUNC_OUT = 1'b1;

  typedef enum logic [1:0] {
    REQ_ITEM,
    REQ_CFG,
    REQ_DRAIN
  } req_kind_e;

  // One entry of the sender's work list: a transaction, a timeout write or a pause.
  typedef struct {
    req_kind_e   kind;
    logic        func;
    logic [31:0] ip;
    logic [15:0] port;
    logic [3:0]  sel;
    logic [31:0] now_ms;
    logic [31:0] timeout;
    int unsigned gap;
  } peer_req_t;

  typedef struct {
    logic [3:0]        slot;
    psti_pkg::status_e status;
    logic [31:0]       ip;
    logic [15:0]       port;
  } slot_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        func_i = 1'b0;
  logic [31:0] peer_ip_i = '0;
  logic [15:0] peer_port_i = '0;
  logic [3:0]  slot_sel_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [3:0]  slot_out_o;
  logic [2:0]  status_o;
  logic [31:0] out_ip_o;
  logic [15:0] out_port_o;

  // Shadow copy of the slot table and its timeout.
  logic [31:0] tbl_ip [SLOTS];
  logic [15:0] tbl_port [SLOTS];
  logic [31:0] tbl_last [SLOTS];
  logic [31:0] idle_timeout = psti_pkg::IdleTimeoutRst;

  peer_req_t    peer_requests [$];
  slot_result_t awaited_results [$];
  int unsigned  gap_limit = 19;
  int unsigned  gap_left = 0;
  int unsigned  n_issued = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_errors = 0;

  peer_slot_table_idle_evict #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .peer_ip_i  (peer_ip_i),
    .peer_port_i(peer_port_i),
    .slot_sel_i (slot_sel_i),
    .now_ms_i   (now_ms_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .slot_out_o (slot_out_o),
    .status_o   (status_o),
    .out_ip_o   (out_ip_o),
    .out_port_o (out_port_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      tbl_ip[k] = '0;
      tbl_port[k] = '0;
      tbl_last[k] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Predicts the result of one transaction and updates the shadow table.
  function automatic slot_result_t resolve_peer(logic func, logic [31:0] ip,
                                                logic [15:0] port, logic [3:0] sel,
                                                logic [31:0] now_ms);
    slot_result_t res;
    logic [31:0]  idle_ms;
    res.slot = 4'(SLOTS);
    res.status = psti_pkg::STAT_FULL;
    res.ip = '0;
    res.port = '0;
    if (func == FUNC_OUT) begin
      res.slot = sel;
      if (sel == 0 || sel >= SLOTS || tbl_port[sel] == 16'd0) begin
        res.status = psti_pkg::STAT_UNASSIGNED;
      end else begin
        tbl_last[sel] = now_ms;
        res.status = psti_pkg::STAT_OUT_OK;
        res.ip = tbl_ip[sel];
        res.port = tbl_port[sel];
      end
      return res;
    end
    // First pass: an empty slot or the same endpoint ends the scan.
    for (int k = 1; k < SLOTS; k++) begin
      if (tbl_port[k] == 16'd0) begin
        tbl_ip[k] = ip;
        tbl_port[k] = port;
        tbl_last[k] = now_ms;
        res.slot = 4'(k);
        res.status = psti_pkg::STAT_NEW;
        return res;
      end
      if (tbl_ip[k] == ip && tbl_port[k] == port) begin
        tbl_last[k] = now_ms;
        res.slot = 4'(k);
        res.status = psti_pkg::STAT_MATCHED;
        return res;
      end
    end
    // Second pass: the first slot idle long enough is taken over.
    for (int k = 1; k < SLOTS; k++) begin
      idle_ms = now_ms - tbl_last[k];
      if (idle_ms >= idle_timeout) begin
        tbl_ip[k] = ip;
        tbl_port[k] = port;
        tbl_last[k] = now_ms;
        res.slot = 4'(k);
        res.status = psti_pkg::STAT_REPLACED;
        return res;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Monitor: checks each result against the oldest prediction, then records
  // timeout writes and newly accepted transactions.
  always @(posedge clk_i) begin : monitor
    slot_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %0h status %0h",
                   $time, slot_out_o, status_o);
          n_errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("slot", 32'(want.slot), 32'(slot_out_o));
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("ip", want.ip, out_ip_o);
          check_field("port", 32'(want.port), 32'(out_port_o));
        end
      end
      if (cfg_we_i) idle_timeout = cfg_wdata_i;
      if (start_i && !busy_o) begin
        awaited_results.push_back(resolve_peer(func_i, peer_ip_i, peer_port_i,
                                               slot_sel_i, now_ms_i));
        n_accepted++;
      end
    end
  end

  // Driver: works through the request list at the falling edge.
  always @(negedge clk_i) begin : driver
    peer_req_t req;
    logic      drive_start;
    logic      drive_we;
    drive_start = start_i;
    drive_we = 1'b0;
    if (rst_ni) begin
      // The transaction on the ports was taken at the last rising edge.
      if (start_i && n_accepted == n_issued) drive_start = 1'b0;
      if (!drive_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (peer_requests.size() != 0) begin
          req = peer_requests[0];
          case (req.kind)
            REQ_ITEM: begin
              peer_requests.delete(0);
              func_i <= req.func;
              peer_ip_i <= req.ip;
              peer_port_i <= req.port;
              slot_sel_i <= req.sel;
              now_ms_i <= req.now_ms;
              drive_start = 1'b1;
              n_issued++;
              gap_left = req.gap;
            end
            REQ_CFG: begin
              if (awaited_results.size() == 0) begin
                peer_requests.delete(0);
                cfg_wdata_i <= req.timeout;
                drive_we = 1'b1;
              end
            end
            REQ_DRAIN: begin
              if (awaited_results.size() == 0) peer_requests.delete(0);
            end
            default: ;
          endcase
        end
      end
    end
    start_i <= drive_start;
    cfg_we_i <= drive_we;
  end

  task automatic push_item(logic func, logic [31:0] ip, logic [15:0] port,
                           logic [3:0] sel, logic [31:0] now_ms);
    peer_req_t req;
    req.kind = REQ_ITEM;
    req.func = func;
    req.ip = ip;
    req.port = port;
    req.sel = sel;
    req.now_ms = now_ms;
    req.timeout = '0;
    req.gap = $urandom_range(0, gap_limit);
    peer_requests.push_back(req);
  endtask

  task automatic push_ctrl(req_kind_e kind, logic [31:0] timeout);
    peer_req_t req;
    req.kind = kind;
    req.func = FUNC_IN;
    req.ip = '0;
    req.port = '0;
    req.sel = '0;
    req.now_ms = '0;
    req.timeout = timeout;
    req.gap = 0;
    peer_requests.push_back(req);
  endtask

  // Stimulus: a directed opening, then phases of random traffic, each under
  // its own idle timeout.
  initial begin : stimulus
    logic [47:0] peer_pool [POOL_SIZE];
    logic [47:0] peer;
    logic [31:0] clock_ms;
    logic [31:0] timeout;
    logic [31:0] max_step;
    int unsigned pick;

    // Outbound to slot zero, an empty slot, the last slot and beyond the table.
    push_item(FUNC_OUT, $urandom, 16'($urandom), 4'd0, 32'd0);
    push_item(FUNC_OUT, $urandom, 16'($urandom), 4'd1, 32'd0);
    push_item(FUNC_OUT, $urandom, 16'($urandom), 4'(SLOTS - 1), 32'd0);
    push_item(FUNC_OUT, $urandom, 16'($urandom), 4'd15, 32'd0);
    // A zero port takes an empty slot but leaves it empty.
    push_item(FUNC_IN, 32'd0, 16'd0, 4'($urandom), 32'd0);
    push_item(FUNC_IN, 32'd1, 16'd1, 4'($urandom), 32'd100);
    push_item(FUNC_IN, 32'd1, 16'd1, 4'($urandom), 32'd200);
    push_item(FUNC_IN, 32'hFFFF_FFFF, 16'hFFFF, 4'($urandom), 32'hFFFF_FFF0);
    push_item(FUNC_OUT, $urandom, 16'($urandom), 4'd2, 32'hFFFF_FFFF);
    push_item(FUNC_OUT, $urandom, 16'($urandom), 4'd1, 32'd300);
    // Fill the rest of the table, then overflow it and evict on the exact boundary.
    for (int k = 3; k < SLOTS; k++) begin
      push_item(FUNC_IN, $urandom, 16'(k), 4'($urandom), 32'd1000);
    end
    push_item(FUNC_IN, 32'hC0DE_0001, 16'h8000, 4'($urandom), 32'd1000);
    push_item(FUNC_IN, 32'hC0DE_0001, 16'h8000, 4'($urandom),
              32'd300 + psti_pkg::IdleTimeoutRst);

    clock_ms = 32'd700000;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: timeout = 32'd0;
        1: timeout = 32'hFFFF_FFFF;
        2: timeout = psti_pkg::IdleTimeoutRst;
        default: timeout = $urandom_range(1, 4000);
      endcase
      max_step = (timeout == 32'd0 || timeout == 32'hFFFF_FFFF) ? 32'd1000 :
                 timeout / 4 + 1;
      gap_limit = (p % 3 == 1) ? 0 : 19;
      for (int k = 0; k < POOL_SIZE; k++) begin
        peer_pool[k] = {32'($urandom), 16'($urandom_range(1, 16'hFFFF))};
      end
      push_ctrl(REQ_CFG, timeout);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Time mostly runs forward; now and then it stalls, steps back or jumps.
        pick = $urandom_range(0, 19);
        if (pick == 0) clock_ms = clock_ms - 32'd1;
        else if (pick == 1) clock_ms = $urandom;
        else if (pick > 5) clock_ms = clock_ms + $urandom_range(0, max_step);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          peer = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
          push_item(FUNC_IN, peer[47:16], peer[15:0], 4'($urandom), clock_ms);
        end else if (pick < 65) begin
          push_item(FUNC_IN, $urandom, 16'($urandom), 4'($urandom), clock_ms);
        end else if (pick < 68) begin
          push_item(FUNC_IN, $urandom, 16'd0, 4'($urandom), clock_ms);
        end else if (pick < 94) begin
          push_item(FUNC_OUT, $urandom, 16'($urandom), 4'($urandom_range(1, SLOTS - 1)),
                    clock_ms);
        end else begin
          push_item(FUNC_OUT, $urandom, 16'($urandom), 4'($urandom), clock_ms);
        end
        if ($urandom_range(0, 39) == 0) push_ctrl(REQ_DRAIN, '0);
      end
    end
    push_ctrl(REQ_CFG, psti_pkg::IdleTimeoutRst);

    while (peer_requests.size() != 0 || awaited_results.size() != 0 || start_i) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("peer_slot_table_idle_evict_tb: clean");
    end else begin
      $display("peer_slot_table_idle_evict_tb: errors");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #4000000;
    $display("peer_slot_table_idle_evict_tb: errors");
    $finish;
  end

endmodule
